// File: rtl/oore_pkg.sv
package oore_pkg;

    localparam int NUM_OCTETS = 4;
    localparam int OCT_W      = 2;
    localparam int SET_BITS   = 256;
    localparam int VAL_W      = 8;
    localparam int CNT_W      = 9;
    localparam int ADDR_W     = 32;
    localparam int PLEN_W     = 6;
    localparam int MODE_W     = 3;
    localparam int GRP_W      = 16;
    localparam int NUM_GRPS   = SET_BITS / GRP_W;

    localparam int SEL_LSB    = 0;
    localparam int FIRST_LSB  = SEL_LSB + OCT_W;
    localparam int LAST_LSB   = FIRST_LSB + VAL_W;
    localparam int ADDR_LSB   = LAST_LSB + VAL_W;
    localparam int PLEN_LSB   = ADDR_LSB + ADDR_W;
    localparam int S_TDATA_W  = 56;

    localparam logic [CNT_W-1:0]  CNT_END  = 9'd256;
    localparam logic [PLEN_W-1:0] PLEN_MAX = 6'd32;

    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RANGE  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SINGLE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PREFIX = 3'd3;
    localparam logic [MODE_W-1:0] MODE_NEXT   = 3'd4;

    localparam logic [1:0] START_CNT  = 2'd0;
    localparam logic [1:0] START_NEXT = 2'd1;
    localparam logic [1:0] START_ZERO = 2'd2;

    localparam logic [1:0] CW_SCAN    = 2'd0;
    localparam logic [1:0] CW_IDX     = 2'd1;
    localparam logic [1:0] CW_END_ALL = 2'd2;

    typedef struct packed {
        logic             clear;
        logic             add_range;
        logic             set_single;
        logic             load_mask;
        logic             widen;
        logic [2:0]       widen_bit;
        logic [OCT_W-1:0] oct;
        logic [1:0]       start_sel;
        logic             cnt_wr;
        logic [1:0]       cnt_sel;
        logic             capture;
        logic             out_load;
        logic             out_found;
    } oore_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] in_mode;
        logic              plen_ok;
        logic              search_found;
        logic              out_free;
    } oore_status_t;

endpackage

// File: rtl/oore_search.sv
module oore_search (
    input  logic                          aclk,
    input  logic [oore_pkg::SET_BITS-1:0] set_bits,
    input  logic [oore_pkg::CNT_W-1:0]    start,
    output logic                          found,
    output logic [oore_pkg::VAL_W-1:0]    idx
);
    import oore_pkg::*;

    logic [SET_BITS-1:0] masked_next, masked_reg;
    logic [NUM_GRPS-1:0] grp_next, grp_reg;

    always_comb begin
        for (int v = 0; v < SET_BITS; v++) begin
            masked_next[v] = set_bits[v] && (CNT_W'(v) >= start);
        end
        for (int g = 0; g < NUM_GRPS; g++) begin
            grp_next[g] = |masked_next[g*GRP_W +: GRP_W];
        end
    end

    always_ff @(posedge aclk) begin
        masked_reg <= masked_next;
        grp_reg    <= grp_next;
    end

    logic [3:0]       gidx;
    logic [3:0]       bidx;
    logic [GRP_W-1:0] grp_bits;

    always_comb begin
        gidx = '0;
        for (int g = NUM_GRPS - 1; g >= 0; g--) begin
            if (grp_reg[g]) begin
                gidx = 4'(g);
            end
        end
        grp_bits = masked_reg[{gidx, 4'b0000} +: GRP_W];
        bidx = '0;
        for (int b = GRP_W - 1; b >= 0; b--) begin
            if (grp_bits[b]) begin
                bidx = 4'(b);
            end
        end
    end

    assign found = |grp_reg;
    assign idx   = {gidx, bidx};

endmodule

// File: rtl/oore_datapath.sv
module oore_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  oore_pkg::oore_cmd_t            cmd,
    output oore_pkg::oore_status_t         status,
    input  logic [oore_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [oore_pkg::MODE_W-1:0]    s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [oore_pkg::ADDR_W-1:0]    m_tdata,
    output logic                           m_tuser
);
    import oore_pkg::*;

    logic [OCT_W-1:0]  in_sel;
    logic [VAL_W-1:0]  in_first;
    logic [VAL_W-1:0]  in_last;
    logic [ADDR_W-1:0] in_addr;
    logic [PLEN_W-1:0] in_plen;

    assign in_sel   = s_tdata[SEL_LSB +: OCT_W];
    assign in_first = s_tdata[FIRST_LSB +: VAL_W];
    assign in_last  = s_tdata[LAST_LSB +: VAL_W];
    assign in_addr  = s_tdata[ADDR_LSB +: ADDR_W];
    assign in_plen  = s_tdata[PLEN_LSB +: PLEN_W];

    logic [SET_BITS-1:0] set_reg  [NUM_OCTETS];
    logic [SET_BITS-1:0] set_next [NUM_OCTETS];
    logic [CNT_W-1:0]    cnt_reg  [NUM_OCTETS];
    logic [CNT_W-1:0]    cnt_next [NUM_OCTETS];
    logic [ADDR_W-1:0]   mask_reg, mask_next;
    logic [ADDR_W-1:0]   addr_reg;
    logic                m_tvalid_reg;
    logic [ADDR_W-1:0]   m_tdata_reg;
    logic                m_tuser_reg;

    logic [CNT_W-1:0]    start;
    logic                srch_found;
    logic [VAL_W-1:0]    srch_idx;

    always_comb begin
        case (cmd.start_sel)
            START_CNT:  start = cnt_reg[cmd.oct];
            START_NEXT: start = cnt_reg[cmd.oct] + CNT_W'(1);
            default:    start = '0;
        endcase
    end

    oore_search u_search (
        .aclk     (aclk),
        .set_bits (set_reg[cmd.oct]),
        .start    (start),
        .found    (srch_found),
        .idx      (srch_idx)
    );

    logic [SET_BITS-1:0] range_mask;
    logic [VAL_W-1:0]    flip;
    logic [VAL_W-1:0]    oct_mask;
    logic [SET_BITS-1:0] widened;

    always_comb begin
        for (int v = 0; v < SET_BITS; v++) begin
            range_mask[v] = (VAL_W'(v) >= in_first) && (VAL_W'(v) <= in_last);
        end
        for (int j = 0; j < ADDR_W; j++) begin
            mask_next[j] = (7'(j) + 7'(in_plen)) >= 7'(ADDR_W);
        end
        flip = VAL_W'(1) << cmd.widen_bit;
        oct_mask = '0;
        widened  = '0;
        for (int o = 0; o < NUM_OCTETS; o++) begin
            set_next[o] = set_reg[o];
            cnt_next[o] = cnt_reg[o];
        end
        if (cmd.clear) begin
            for (int o = 0; o < NUM_OCTETS; o++) begin
                set_next[o] = '0;
                cnt_next[o] = '0;
            end
        end
        if (cmd.add_range) begin
            set_next[in_sel] = set_reg[in_sel] | range_mask;
        end
        if (cmd.set_single) begin
            for (int o = 0; o < NUM_OCTETS; o++) begin
                set_next[o] = '0;
                set_next[o][in_addr[VAL_W*(NUM_OCTETS-1-o) +: VAL_W]] = 1'b1;
                cnt_next[o] = '0;
            end
        end
        if (cmd.widen) begin
            for (int o = 0; o < NUM_OCTETS; o++) begin
                oct_mask = mask_reg[VAL_W*(NUM_OCTETS-1-o) +: VAL_W];
                for (int v = 0; v < SET_BITS; v++) begin
                    widened[v] = set_reg[o][v] | set_reg[o][VAL_W'(v) ^ flip];
                end
                if (!oct_mask[cmd.widen_bit]) begin
                    set_next[o] = widened;
                end
            end
        end
        if (cmd.cnt_wr) begin
            case (cmd.cnt_sel)
                CW_SCAN: begin
                    cnt_next[cmd.oct] = srch_found ? {1'b0, srch_idx} : CNT_END;
                end
                CW_IDX: begin
                    cnt_next[cmd.oct] = {1'b0, srch_idx};
                end
                CW_END_ALL: begin
                    for (int o = 0; o < NUM_OCTETS; o++) begin
                        cnt_next[o] = CNT_END;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int o = 0; o < NUM_OCTETS; o++) begin
                set_reg[o] <= '0;
                cnt_reg[o] <= '0;
            end
            m_tvalid_reg <= 1'b0;
        end else begin
            for (int o = 0; o < NUM_OCTETS; o++) begin
                set_reg[o] <= set_next[o];
                cnt_reg[o] <= cnt_next[o];
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_mask) begin
            mask_reg <= mask_next;
        end
        if (cmd.capture) begin
            addr_reg <= {cnt_reg[0][VAL_W-1:0], cnt_reg[1][VAL_W-1:0],
                         cnt_reg[2][VAL_W-1:0], srch_idx};
        end
        if (cmd.out_load) begin
            m_tdata_reg <= cmd.out_found ? addr_reg : '0;
            m_tuser_reg <= cmd.out_found;
        end
    end

    assign status.in_mode      = s_tuser;
    assign status.plen_ok      = in_plen <= PLEN_MAX;
    assign status.search_found = srch_found;
    assign status.out_free     = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// File: rtl/oore_ctrl.sv
module oore_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  oore_pkg::oore_status_t status,
    output oore_pkg::oore_cmd_t    cmd
);
    import oore_pkg::*;

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_WIDEN     = 4'd1;
    localparam logic [3:0] ST_SCAN_GO   = 4'd2;
    localparam logic [3:0] ST_SCAN_WAIT = 4'd3;
    localparam logic [3:0] ST_ADV_GO    = 4'd4;
    localparam logic [3:0] ST_ADV_WAIT  = 4'd5;
    localparam logic [3:0] ST_WRAP_GO   = 4'd6;
    localparam logic [3:0] ST_WRAP_WAIT = 4'd7;
    localparam logic [3:0] ST_RESULT    = 4'd8;

    logic [3:0]       state_reg, state_next;
    logic [OCT_W-1:0] oct_reg, oct_next;
    logic [2:0]       bit_reg, bit_next;
    logic             found_reg, found_next;

    always_comb begin
        state_next    = state_reg;
        oct_next      = oct_reg;
        bit_next      = bit_reg;
        found_next    = found_reg;
        cmd           = '0;
        cmd.oct       = oct_reg;
        cmd.widen_bit = bit_reg;
        s_tready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    case (status.in_mode)
                        MODE_CLEAR:  cmd.clear = 1'b1;
                        MODE_RANGE:  cmd.add_range = 1'b1;
                        MODE_SINGLE: cmd.set_single = 1'b1;
                        MODE_PREFIX: begin
                            cmd.load_mask = 1'b1;
                            bit_next = '0;
                            if (status.plen_ok) begin
                                state_next = ST_WIDEN;
                            end
                        end
                        MODE_NEXT: begin
                            oct_next   = '0;
                            state_next = ST_SCAN_GO;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_WIDEN: begin
                cmd.widen = 1'b1;
                bit_next  = bit_reg + 3'd1;
                if (bit_reg == 3'd7) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN_GO: begin
                cmd.start_sel = START_CNT;
                state_next    = ST_SCAN_WAIT;
            end
            ST_SCAN_WAIT: begin
                cmd.cnt_wr  = 1'b1;
                cmd.cnt_sel = CW_SCAN;
                if (!status.search_found) begin
                    found_next = 1'b0;
                    state_next = ST_RESULT;
                end else if (oct_reg == OCT_W'(NUM_OCTETS - 1)) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_ADV_GO;
                end else begin
                    oct_next   = oct_reg + OCT_W'(1);
                    state_next = ST_SCAN_GO;
                end
            end
            ST_ADV_GO: begin
                cmd.start_sel = START_NEXT;
                state_next    = ST_ADV_WAIT;
            end
            ST_ADV_WAIT: begin
                if (status.search_found) begin
                    cmd.cnt_wr  = 1'b1;
                    cmd.cnt_sel = CW_IDX;
                    found_next  = 1'b1;
                    state_next  = ST_RESULT;
                end else begin
                    state_next = ST_WRAP_GO;
                end
            end
            ST_WRAP_GO: begin
                cmd.start_sel = START_ZERO;
                state_next    = ST_WRAP_WAIT;
            end
            ST_WRAP_WAIT: begin
                cmd.cnt_wr = 1'b1;
                found_next = 1'b1;
                if (oct_reg == '0) begin
                    cmd.cnt_sel = CW_END_ALL;
                    state_next  = ST_RESULT;
                end else begin
                    cmd.cnt_sel = CW_IDX;
                    oct_next    = oct_reg - OCT_W'(1);
                    state_next  = ST_ADV_GO;
                end
            end
            ST_RESULT: begin
                if (status.out_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.out_found = found_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            oct_reg   <= '0;
            bit_reg   <= '0;
            found_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            oct_reg   <= oct_next;
            bit_reg   <= bit_next;
            found_reg <= found_next;
        end
    end

endmodule

// File: rtl/ipv4_octet_range_enumerator.sv
// Enumerates IPv4 addresses from four 256-bit membership sets, one per octet. Clear, add
// range and single-address transfers finish in the cycle they are accepted. A prefix
// transfer of length up to 32 then widens the sets in one step for each bit position of an
// octet. A next transfer scans each octet for its current member with the find-next-member
// unit, a two-stage search over a 256-bit set, and reports nothing found if one has none;
// else it steps the lowest octet to its next member, moves a wrapped octet back to its first
// member and steps the octet above it, sets every octet to its end when the top octet wraps,
// and loads the result once the output holds no earlier result. The result sits in an
// output register, so the block returns to accepting transfers as soon as it is written.
module ipv4_octet_range_enumerator (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // octet_sel, range_first, range_last, address, prefix_len
    input  logic [oore_pkg::S_TDATA_W-1:0] s_tdata,
    // mode
    input  logic [oore_pkg::MODE_W-1:0]    s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // next_address
    output logic [oore_pkg::ADDR_W-1:0]    m_tdata,
    // found
    output logic                           m_tuser
);
    import oore_pkg::*;

    oore_cmd_t    cmd;
    oore_status_t status;

    oore_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    oore_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// File: rtl/oore_checker.sv
module oore_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [oore_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [oore_pkg::MODE_W-1:0]    s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [oore_pkg::ADDR_W-1:0]    m_tdata,
    input logic                           m_tuser
);
    import oore_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("Result changed while stalled.");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("Exhausted result carries a nonzero address.");

    a_next_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == MODE_NEXT |=> !s_tready)
        else $error("Next transfer did not occupy the block.");

    a_prefix_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == MODE_PREFIX
        && s_tdata[PLEN_LSB +: PLEN_W] <= PLEN_MAX |=> !s_tready)
        else $error("Prefix transfer did not occupy the block.");

    a_clear_fast: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == MODE_CLEAR |=> s_tready)
        else $error("Clear transfer stalled the input.");

endmodule

bind ipv4_octet_range_enumerator oore_checker u_oore_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: bench/ipv4_octet_range_enumerator_tb.sv
module ipv4_octet_range_enumerator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import oore_pkg::*;

    localparam int ITEM_TARGET = 650;
    localparam int IDLE_PCT    = 38;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 60;

    localparam logic [MODE_W-1:0] MODE_RSVD_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_RSVD_HI = 3'd7;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              found;
    } addr_result_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [MODE_W-1:0]    s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [ADDR_W-1:0]    m_tdata;
    logic                 m_tuser;

    logic [SET_BITS-1:0] octet_set [NUM_OCTETS];
    logic [CNT_W-1:0]    octet_pos [NUM_OCTETS];
    addr_result_t        expected_addrs[$];

    int  mismatches = 0;
    int  items_sent = 0;
    int  cycles     = 0;
    bit  no_idle    = 1'b0;

    ipv4_octet_range_enumerator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     expected_addrs.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    task automatic log_mismatch(input string what, input logic [ADDR_W-1:0] got,
                                input logic [ADDR_W-1:0] want);
        $display("mismatch at cycle %0d: %s got %h expected %h", cycles, what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        addr_result_t want;
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            if (expected_addrs.size() == 0) begin
                log_mismatch("unexpected transfer", m_tdata, '0);
            end else begin
                want = expected_addrs.pop_front();
                if (m_tuser !== want.found)
                    log_mismatch("found", ADDR_W'(m_tuser), ADDR_W'(want.found));
                if (m_tdata !== want.addr)
                    log_mismatch("next_address", m_tdata, want.addr);
            end
        end
    end

    // Mirrors the block: updates the octet sets and counters for one accepted transfer and
    // queues the address a next request produces.
    task automatic advance_enumeration(input logic [MODE_W-1:0] mode,
                                       input logic [OCT_W-1:0] sel,
                                       input logic [VAL_W-1:0] first,
                                       input logic [VAL_W-1:0] last,
                                       input logic [ADDR_W-1:0] addr,
                                       input logic [PLEN_W-1:0] plen);
        logic [ADDR_W-1:0]   mask;
        logic [VAL_W-1:0]    mask8;
        logic [SET_BITS-1:0] widened;
        logic [ADDR_W-1:0]   result;
        logic [CNT_W-1:0]    c;
        addr_result_t        entry;
        bit                  carry;
        bit                  hit;
        bit                  dead;
        int                  o;
        int                  b;
        int                  v;
        int                  stepn;
        int                  idx;
        case (mode)
            MODE_CLEAR: begin
                for (o = 0; o < NUM_OCTETS; o++) begin
                    octet_set[o] = '0;
                    octet_pos[o] = '0;
                end
            end
            MODE_RANGE: begin
                if (last >= first)
                    for (v = int'(first); v <= int'(last); v++)
                        octet_set[sel][v] = 1'b1;
            end
            MODE_SINGLE: begin
                for (o = 0; o < NUM_OCTETS; o++) begin
                    octet_set[o] = '0;
                    octet_set[o][addr[31-8*o -: 8]] = 1'b1;
                    octet_pos[o] = '0;
                end
            end
            MODE_PREFIX: begin
                if (plen <= PLEN_MAX) begin
                    mask = (plen == 0) ? '0 : (32'hFFFF_FFFF << (32 - int'(plen)));
                    for (o = 0; o < NUM_OCTETS; o++) begin
                        mask8 = mask[31-8*o -: 8];
                        for (b = 0; b < VAL_W; b++) begin
                            if (!mask8[b]) begin
                                widened = octet_set[o];
                                for (v = 0; v < SET_BITS; v++)
                                    if (octet_set[o][v ^ (1 << b)])
                                        widened[v] = 1'b1;
                                octet_set[o] = widened;
                            end
                        end
                    end
                end
            end
            MODE_NEXT: begin
                dead = 1'b0;
                for (o = 0; o < NUM_OCTETS && !dead; o++) begin
                    while (octet_pos[o] < CNT_END && !octet_set[o][octet_pos[o][7:0]])
                        octet_pos[o]++;
                    if (octet_pos[o] >= CNT_END)
                        dead = 1'b1;
                end
                if (dead) begin
                    entry.addr  = '0;
                    entry.found = 1'b0;
                    expected_addrs = {expected_addrs, entry};
                end else begin
                    result = {octet_pos[0][7:0], octet_pos[1][7:0],
                              octet_pos[2][7:0], octet_pos[3][7:0]};
                    carry = 1'b1;
                    for (o = NUM_OCTETS - 1; o >= 0 && carry; o--) begin
                        c = octet_pos[o];
                        carry = 1'b0;
                        hit = 1'b0;
                        for (stepn = 1; stepn <= SET_BITS && !hit; stepn++) begin
                            if (int'(c) + stepn >= SET_BITS)
                                carry = 1'b1;
                            idx = (int'(c) + stepn) % SET_BITS;
                            if (octet_set[o][idx]) begin
                                hit = 1'b1;
                                octet_pos[o] = CNT_W'(idx);
                            end
                        end
                    end
                    if (carry)
                        for (o = 0; o < NUM_OCTETS; o++)
                            octet_pos[o] = CNT_END;
                    entry.addr  = result;
                    entry.found = 1'b1;
                    expected_addrs = {expected_addrs, entry};
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [OCT_W-1:0] sel,
                             input logic [VAL_W-1:0] first, input logic [VAL_W-1:0] last,
                             input logic [ADDR_W-1:0] addr, input logic [PLEN_W-1:0] plen);
        if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < IDLE_PCT);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {plen, addr, last, first, sel};
        s_tuser  <= mode;
        do @(posedge aclk); while (s_tready !== 1'b1);
        advance_enumeration(mode, sel, first, last, addr, plen);
        items_sent++;
    endtask

    task automatic send_next();
        send_item(MODE_NEXT, OCT_W'($urandom_range(3)), VAL_W'($urandom_range(255)),
                  VAL_W'($urandom_range(255)), $urandom, PLEN_W'($urandom_range(63)));
    endtask

    task automatic send_range(input logic [OCT_W-1:0] sel, input logic [VAL_W-1:0] first,
                              input logic [VAL_W-1:0] last);
        send_item(MODE_RANGE, sel, first, last, $urandom, PLEN_W'($urandom_range(63)));
    endtask

    task automatic send_control(input logic [MODE_W-1:0] mode, input logic [ADDR_W-1:0] addr,
                                input logic [PLEN_W-1:0] plen);
        send_item(mode, OCT_W'($urandom_range(3)), VAL_W'($urandom_range(255)),
                  VAL_W'($urandom_range(255)), addr, plen);
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_addrs.size() != 0);
    endtask

    task automatic seq_single_prefix();
        int n;
        send_control(MODE_SINGLE, $urandom, PLEN_W'($urandom_range(63)));
        if ($urandom_range(3) != 0)
            send_control(MODE_PREFIX, $urandom,
                         PLEN_W'(($urandom_range(3) == 0) ? $urandom_range(0, 32)
                                                          : $urandom_range(28, 32)));
        n = $urandom_range(1, 10);
        repeat (n) send_next();
    endtask

    task automatic seq_ranges();
        int o;
        int n;
        logic [VAL_W-1:0] first;
        logic [VAL_W-1:0] last;
        send_control(MODE_CLEAR, $urandom, PLEN_W'($urandom_range(63)));
        for (o = 0; o < NUM_OCTETS; o++) begin
            if ($urandom_range(15) != 0) begin
                first = VAL_W'($urandom_range(255));
                last = (first > 252) ? 8'd255 : VAL_W'(first + $urandom_range(3));
                if ($urandom_range(7) == 0)
                    send_range(OCT_W'(o), VAL_W'(last + 1 + $urandom_range(3)), last);
                send_range(OCT_W'(o), first, last);
                if ($urandom_range(5) == 0)
                    send_range(OCT_W'(o), VAL_W'($urandom_range(255)),
                               VAL_W'($urandom_range(255)));
            end
        end
        n = $urandom_range(1, 12);
        repeat (n) send_next();
    endtask

    task automatic seq_noise();
        int n;
        n = $urandom_range(1, 3);
        repeat (n)
            send_item(MODE_W'($urandom_range(7)), OCT_W'($urandom_range(3)),
                      VAL_W'($urandom_range(255)), VAL_W'($urandom_range(255)), $urandom,
                      PLEN_W'($urandom_range(63)));
    endtask

    task automatic run_random_sequence();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            seq_single_prefix();
        else if (r < 80)
            seq_ranges();
        else
            seq_noise();
    endtask

    // The all-ones address enumerates once and then reports exhaustion; the all-zeros address enumerates once.
    task automatic test_single_address();
        send_control(MODE_CLEAR, '0, '0);
        send_control(MODE_SINGLE, 32'hFFFF_FFFF, 6'h3F);
        send_next();
        send_next();
        send_control(MODE_SINGLE, '0, '0);
        send_next();
    endtask

    // Two values in each of the two lower octets give four addresses, a reversed range is
    // ignored, and a next over an empty octet set reports nothing found.
    task automatic test_octet_ranges();
        send_control(MODE_CLEAR, $urandom, PLEN_W'($urandom_range(63)));
        send_range(2'd0, 8'd0, 8'd0);
        send_range(2'd1, 8'd255, 8'd255);
        send_range(2'd2, 8'd0, 8'd1);
        send_range(2'd3, 8'd254, 8'd255);
        send_range(2'd3, 8'd200, 8'd100);
        repeat (5) send_next();
        send_control(MODE_CLEAR, $urandom, PLEN_W'($urandom_range(63)));
        send_range(2'd0, 8'd0, 8'd255);
        send_next();
    endtask

    // Legal prefixes widen the sets; out-of-range prefixes and reserved modes must leave the state untouched.
    task automatic test_prefix_and_reserved();
        logic [MODE_W-1:0] m;
        send_control(MODE_SINGLE, 32'hC0A8_0101, '0);
        send_control(MODE_PREFIX, $urandom, 6'd33);
        send_control(MODE_PREFIX, $urandom, PLEN_MAX);
        send_control(MODE_PREFIX, $urandom, 6'd30);
        send_next();
        send_control(MODE_PREFIX, $urandom, 6'd0);
        send_next();
        for (m = MODE_RSVD_LO; m <= MODE_RSVD_HI && m >= MODE_RSVD_LO; m++)
            send_item(m, OCT_W'($urandom_range(3)), VAL_W'($urandom_range(255)),
                      VAL_W'($urandom_range(255)), $urandom, PLEN_W'($urandom_range(63)));
        send_next();
    endtask

    task automatic test_back_to_back();
        wait_drain();
        no_idle = 1'b1;
        while (items_sent < 130)
            run_random_sequence();
        wait_drain();
        no_idle = 1'b0;
    endtask

    task automatic test_random_mix();
        while (items_sent < ITEM_TARGET)
            run_random_sequence();
    endtask

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= MODE_CLEAR;
        m_tready <= 1'b0;
        for (int o = 0; o < NUM_OCTETS; o++) begin
            octet_set[o] = '0;
            octet_pos[o] = '0;
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_single_address();
        test_octet_ranges();
        test_prefix_and_reserved();
        test_back_to_back();
        test_random_mix();

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
